// ----- rtl/npcm_pkg.sv -----
package npcm_pkg;

	localparam int ENTRIES   = 256;
	localparam int FRAC_BITS = 14;

	localparam int ADDR_W = $clog2(ENTRIES);
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 9;
	localparam int VEC_W  = 16;
	localparam int BYTE_W = 8;
	localparam int DEC_W  = 10;
	localparam int PROD_W = VEC_W + DEC_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int CMD_W  = 3;

	localparam logic signed [VEC_W-1:0] ONE      = VEC_W'(2 ** FRAC_BITS);
	localparam logic signed [DOT_W-1:0] BEST_INIT = -DOT_W'(255 * (2 ** FRAC_BITS));
	localparam logic [CNT_W-1:0]        CNT_MAX   = CNT_W'(ENTRIES);

	localparam logic [CMD_W-1:0] CMD_WR_ENC  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_RAW  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET_CNT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

	typedef struct packed {
		logic capture;
		logic mem_wr_enc;
		logic mem_wr_raw;
		logic set_count;
		logic clr_res;
		logic scan_en;
		logic load_entry;
		logic out_load;
	} dp_ctrl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             count_zero;
		logic             scan_last;
		logic             pipe_busy;
		logic             out_free;
	} dp_stat_t;

	function automatic logic signed [VEC_W-1:0] clamp_one(input logic signed [VEC_W-1:0] q);
		logic signed [VEC_W-1:0] r;
		if (q > ONE)
			r = ONE;
		else if (q < -ONE)
			r = -ONE;
		else
			r = q;
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] encode_comp(input logic signed [VEC_W-1:0] q);
		logic signed [VEC_W:0] s;
		logic [VEC_W+BYTE_W:0] p;
		s = (VEC_W+1)'(q) + (VEC_W+1)'(ONE);
		p = {unsigned'(s), 8'd0} - {8'd0, unsigned'(s)};
		return p[FRAC_BITS+BYTE_W -: BYTE_W];
	endfunction

	function automatic logic signed [DEC_W-1:0] decode_comp(input logic [BYTE_W-1:0] c);
		return $signed({1'b0, c, 1'b0}) - 10'sd255;
	endfunction

endpackage

// ----- rtl/npcm_ctrl.sv -----
module npcm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  npcm_pkg::dp_stat_t  stat,
	output npcm_pkg::dp_ctrl_t  ctrl
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctrl.capture = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctrl.clr_res = 1'b1;
				state_d      = ST_DONE;
				case (stat.cmd)
					npcm_pkg::CMD_WR_ENC:  ctrl.mem_wr_enc = 1'b1;
					npcm_pkg::CMD_WR_RAW:  ctrl.mem_wr_raw = 1'b1;
					npcm_pkg::CMD_SET_CNT: ctrl.set_count  = 1'b1;
					npcm_pkg::CMD_QUERY: begin
						if (!stat.count_zero)
							state_d = ST_SCAN;
					end
					npcm_pkg::CMD_READ:    state_d = ST_READ;
					default:               state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				ctrl.scan_en = 1'b1;
				if (stat.scan_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy)
					state_d = ST_DONE;
			end
			ST_READ: begin
				ctrl.load_entry = 1'b1;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/npcm_dp.sv -----
module npcm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  npcm_pkg::dp_ctrl_t                  ctrl,
	output npcm_pkg::dp_stat_t                  stat,
	input  logic [npcm_pkg::CMD_W-1:0]          in_command,
	input  logic [npcm_pkg::IDX_W-1:0]          in_entry_index,
	input  logic signed [npcm_pkg::VEC_W-1:0]   in_vec_x,
	input  logic signed [npcm_pkg::VEC_W-1:0]   in_vec_y,
	input  logic signed [npcm_pkg::VEC_W-1:0]   in_vec_z,
	input  logic [npcm_pkg::BYTE_W-1:0]         in_raw_red,
	input  logic [npcm_pkg::BYTE_W-1:0]         in_raw_green,
	input  logic [npcm_pkg::BYTE_W-1:0]         in_raw_blue,
	input  logic [npcm_pkg::CNT_W-1:0]          in_new_count,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [npcm_pkg::IDX_W-1:0]          match_index,
	output logic                                found,
	output logic [npcm_pkg::BYTE_W-1:0]         entry_red,
	output logic [npcm_pkg::BYTE_W-1:0]         entry_green,
	output logic [npcm_pkg::BYTE_W-1:0]         entry_blue
);

	logic [3*npcm_pkg::BYTE_W-1:0] mem [npcm_pkg::ENTRIES];

	logic [npcm_pkg::CMD_W-1:0]        cmd_q;
	logic [npcm_pkg::IDX_W-1:0]        idx_q;
	logic signed [npcm_pkg::VEC_W-1:0] vx_q, vy_q, vz_q;
	logic [3*npcm_pkg::BYTE_W-1:0]     raw_q;
	logic [npcm_pkg::CNT_W-1:0]        nc_q;
	logic [npcm_pkg::CNT_W-1:0]        count_q;
	logic [npcm_pkg::CNT_W-1:0]        ptr_q;
	logic [3*npcm_pkg::BYTE_W-1:0]     rd_q;

	logic                               v_s1, v_s2;
	logic [npcm_pkg::IDX_W-1:0]         idx_s1, idx_s2;
	logic signed [npcm_pkg::PROD_W-1:0] px_s2, py_s2, pz_s2;
	logic signed [npcm_pkg::DOT_W-1:0]  best_q, dot;

	logic [npcm_pkg::IDX_W-1:0]  res_idx_q;
	logic                        res_found_q;
	logic [3*npcm_pkg::BYTE_W-1:0] res_ent_q;
	logic                        out_valid_q;

	logic [npcm_pkg::CNT_W-1:0]    idx_p1;
	logic                          in_range;
	logic [npcm_pkg::ADDR_W-1:0]   wr_addr, rd_addr;
	logic [3*npcm_pkg::BYTE_W-1:0] enc_word, wr_word;

	assign idx_p1   = {1'b0, idx_q} + npcm_pkg::CNT_W'(1);
	assign in_range = {1'b0, idx_q} < npcm_pkg::CNT_MAX;
	assign wr_addr  = npcm_pkg::ADDR_W'(idx_q);
	assign rd_addr  = ctrl.scan_en ? ptr_q[npcm_pkg::ADDR_W-1:0] : npcm_pkg::ADDR_W'(idx_q);
	assign enc_word = {npcm_pkg::encode_comp(vx_q), npcm_pkg::encode_comp(vy_q),
		npcm_pkg::encode_comp(vz_q)};
	assign wr_word  = ctrl.mem_wr_raw ? raw_q : enc_word;

	always_ff @(posedge clk) begin
		if ((ctrl.mem_wr_enc || ctrl.mem_wr_raw) && in_range)
			mem[wr_addr] <= wr_word;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q <= in_command;
			idx_q <= in_entry_index;
			vx_q  <= npcm_pkg::clamp_one(in_vec_x);
			vy_q  <= npcm_pkg::clamp_one(in_vec_y);
			vz_q  <= npcm_pkg::clamp_one(in_vec_z);
			raw_q <= {in_raw_red, in_raw_green, in_raw_blue};
			nc_q  <= in_new_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.set_count) begin
			count_q <= (nc_q > npcm_pkg::CNT_MAX) ? npcm_pkg::CNT_MAX : nc_q;
		end else if (ctrl.mem_wr_enc && in_range && (count_q < idx_p1)) begin
			count_q <= idx_p1;
		end
	end

	// search pipeline: address, read, products, compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.scan_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clr_res)
			ptr_q <= '0;
		else if (ctrl.scan_en)
			ptr_q <= ptr_q + npcm_pkg::CNT_W'(1);
		idx_s1 <= npcm_pkg::IDX_W'(ptr_q);
		idx_s2 <= idx_s1;
		px_s2  <= vx_q * npcm_pkg::decode_comp(rd_q[23:16]);
		py_s2  <= vy_q * npcm_pkg::decode_comp(rd_q[15:8]);
		pz_s2  <= vz_q * npcm_pkg::decode_comp(rd_q[7:0]);
	end

	assign dot = npcm_pkg::DOT_W'(px_s2) + npcm_pkg::DOT_W'(py_s2) + npcm_pkg::DOT_W'(pz_s2);

	always_ff @(posedge clk) begin
		if (ctrl.clr_res) begin
			best_q      <= npcm_pkg::BEST_INIT;
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
			res_ent_q   <= '0;
		end else begin
			if (v_s2 && (dot > best_q)) begin
				best_q      <= dot;
				res_idx_q   <= idx_s2;
				res_found_q <= 1'b1;
			end
			if (ctrl.load_entry)
				res_ent_q <= in_range ? rd_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctrl.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			match_index <= res_idx_q;
			found       <= res_found_q;
			entry_red   <= res_ent_q[23:16];
			entry_green <= res_ent_q[15:8];
			entry_blue  <= res_ent_q[7:0];
		end
	end

	assign m_tvalid        = out_valid_q;
	assign stat.cmd        = cmd_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.scan_last  = (ptr_q + npcm_pkg::CNT_W'(1)) == count_q;
	assign stat.pipe_busy  = v_s1 || v_s2;
	assign stat.out_free   = !out_valid_q || m_tready;

endmodule

// ----- rtl/normal_palette_closest_match.sv -----
// a query walks the table through the read port one entry per cycle, then waits for the
// search pipeline to drain before the result is loaded; on an empty table it skips the walk
// other commands (write, set count, unknown) go straight to the result; read first reads the table
// throughput: one command at a time; the next beat is taken once the result sits in the
// output register
// reset clears the controller, output valid and entry count; table contents are undefined
module normal_palette_closest_match (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index, vec_x, vec_y, vec_z, raw_red, raw_green, raw_blue, new_count, zero pad
	input  logic [95:0] s_tdata,
	input  logic [2:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // match_index, entry_red, entry_green, entry_blue
	output logic        m_tuser   // found
);

	npcm_pkg::dp_ctrl_t ctrl;
	npcm_pkg::dp_stat_t stat;

	logic [npcm_pkg::IDX_W-1:0]  match_index;
	logic                        found;
	logic [npcm_pkg::BYTE_W-1:0] entry_red, entry_green, entry_blue;

	npcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	npcm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.in_command     (s_tuser),
		.in_entry_index (s_tdata[7:0]),
		.in_vec_x       (s_tdata[23:8]),
		.in_vec_y       (s_tdata[39:24]),
		.in_vec_z       (s_tdata[55:40]),
		.in_raw_red     (s_tdata[63:56]),
		.in_raw_green   (s_tdata[71:64]),
		.in_raw_blue    (s_tdata[79:72]),
		.in_new_count   (s_tdata[88:80]),
		.m_tready       (m_tready),
		.m_tvalid       (m_tvalid),
		.match_index    (match_index),
		.found          (found),
		.entry_red      (entry_red),
		.entry_green    (entry_green),
		.entry_blue     (entry_blue)
	);

	assign m_tdata = {entry_blue, entry_green, entry_red, match_index};
	assign m_tuser = found;

endmodule
